FILE: rtl/tpg_pkg.sv
package tpg_pkg;

  localparam int CFG_W   = 13;
  localparam int IDX_W   = 2;
  localparam int COORD_W = 12;
  localparam int COLOR_W = 24;
  localparam int GEO_W   = 15;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);

  // Register stages between the frame size registers and the geometry the
  // pixel datapath uses.
  localparam int GEO_LAT = 4;

  typedef logic signed [GEO_W-1:0] coord_t;

  // Precomputed edges of every rectangle of the pattern. Right and bottom
  // edges are exclusive.
  typedef struct packed {
    coord_t       w;
    coord_t       h;
    coord_t       b;
    coord_t [8:0] bar_x;
    coord_t       bar_y1;
    coord_t       red_x1;
    coord_t       mk_y0;
    coord_t       mk_y1;
    coord_t       grn_x0;
    coord_t       inner_x1;
    coord_t       blu_x0;
    coord_t       blu_x1;
    coord_t       blu_y0;
    coord_t       inner_y1;
    coord_t [8:0] chk_x;
    coord_t [6:0] chk_y;
  } geom_t;

endpackage

FILE: rtl/tpg_cfg.sv
module tpg_cfg #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tpg_pkg::IDX_W-1:0]   cfg_index,
  input  logic [tpg_pkg::CFG_W-1:0]   cfg_data,
  output logic [tpg_pkg::CFG_W-1:0]   frame_width,
  output logic [tpg_pkg::CFG_W-1:0]   frame_height,
  output logic                        busy
);
  import tpg_pkg::*;

  localparam int CFG_MAX = 2 ** CFG_W - 1;
  localparam logic [CFG_W-1:0] DIM_CAP =
    CFG_W'((MAX_DIMENSION > CFG_MAX) ? CFG_MAX : MAX_DIMENSION);
  localparam int BUSY_W = $clog2(GEO_LAT + 1);

  localparam logic [CFG_W-1:0] RST_WIDTH  = CFG_W'(640);
  localparam logic [CFG_W-1:0] RST_HEIGHT = CFG_W'(480);

  logic [CFG_W-1:0]  data_clamped;
  logic [BUSY_W-1:0] busy_cnt;

  always_comb begin
    if (cfg_data == '0) begin
      data_clamped = CFG_W'(1);
    end else if (cfg_data > DIM_CAP) begin
      data_clamped = DIM_CAP;
    end else begin
      data_clamped = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_WIDTH;
      frame_height <= RST_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= data_clamped;
        REG_FRAME_HEIGHT: frame_height <= data_clamped;
        default: ;
      endcase
    end
  end

  // The geometry pipeline refills after reset and after every write.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_cnt <= BUSY_W'(GEO_LAT);
    end else if (cfg_we) begin
      busy_cnt <= BUSY_W'(GEO_LAT);
    end else if (busy_cnt != '0) begin
      busy_cnt <= busy_cnt - BUSY_W'(1);
    end
  end

  assign busy = (busy_cnt != '0);

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) cfg_we |=> busy)
    else $error("geometry not held off after a register write");
  assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == REG_FRAME_WIDTH) |=>
      (frame_width != '0) && (frame_width <= DIM_CAP))
    else $error("frame width outside its legal range");
  assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == REG_FRAME_HEIGHT) |=>
      (frame_height != '0) && (frame_height <= DIM_CAP))
    else $error("frame height outside its legal range");
`endif

endmodule

FILE: rtl/tpg_geom.sv
module tpg_geom (
  input  logic                      clk,
  input  logic [tpg_pkg::CFG_W-1:0] frame_width,
  input  logic [tpg_pkg::CFG_W-1:0] frame_height,
  output tpg_pkg::geom_t            geom
);
  import tpg_pkg::*;

  localparam int PROD_W = 32;

  // Reciprocal constants, exact for every 13-bit dividend.
  localparam int DIV7_MUL  = 9363;
  localparam int DIV7_SH   = 16;
  localparam int DIV5_MUL  = 13108;
  localparam int DIV5_SH   = 16;
  localparam int DIV18_MUL = 7282;
  localparam int DIV18_SH  = 17;
  localparam int DIV24_MUL = 10923;
  localparam int DIV24_SH  = 18;

  localparam int WIDE_MIN    = 64;
  localparam int BORDER_THIN = 1;
  localparam int BORDER_WIDE = 4;
  localparam int BAR_MIN_H   = 12;
  localparam int MARK_MIN    = 4;
  localparam int TILE_MIN    = 2;

  // Halving that rounds toward zero.
  function automatic coord_t half_tz(coord_t v);
    coord_t adj;
    adj = v + coord_t'(v < 0);
    return adj >>> 1;
  endfunction

  logic [CFG_W-1:0]  min_wh;
  logic [PROD_W-1:0] prod7, prod5, prod18, prod24;

  logic [CFG_W-1:0] w1, h1, q7, q5, q18, q24;
  logic             big1;

  coord_t w2, h2, b2, bh2, mw2, mh2, t2;
  coord_t bar_x2 [9];

  coord_t w3, h3, b3, mw3, mh3, ox3, oy3, mky3;
  coord_t grn_x0_3, inner_x1_3, blu_x0_3, blu_y0_3, inner_y1_3, bar_y1_3, red_x1_3;
  coord_t kt3    [9];
  coord_t bar_x3 [9];

  always_comb begin
    min_wh = (frame_width < frame_height) ? frame_width : frame_height;
    prod7  = PROD_W'(frame_height) * PROD_W'(DIV7_MUL);
    prod5  = PROD_W'(frame_height) * PROD_W'(DIV5_MUL);
    prod18 = PROD_W'(frame_width) * PROD_W'(DIV18_MUL);
    prod24 = PROD_W'(min_wh) * PROD_W'(DIV24_MUL);
  end

  always_ff @(posedge clk) begin
    w1   <= frame_width;
    h1   <= frame_height;
    q7   <= prod7[DIV7_SH +: CFG_W];
    q5   <= prod5[DIV5_SH +: CFG_W];
    q18  <= prod18[DIV18_SH +: CFG_W];
    q24  <= prod24[DIV24_SH +: CFG_W];
    big1 <= (frame_width >= CFG_W'(WIDE_MIN)) && (frame_height >= CFG_W'(WIDE_MIN));
  end

  always_ff @(posedge clk) begin
    w2  <= coord_t'(w1);
    h2  <= coord_t'(h1);
    b2  <= big1 ? coord_t'(BORDER_WIDE) : coord_t'(BORDER_THIN);
    bh2 <= (q7 > CFG_W'(BAR_MIN_H)) ? coord_t'(q7) : coord_t'(BAR_MIN_H);
    mw2 <= (q18 > CFG_W'(MARK_MIN)) ? coord_t'(q18) : coord_t'(MARK_MIN);
    mh2 <= (q5 > CFG_W'(MARK_MIN)) ? coord_t'(q5) : coord_t'(MARK_MIN);
    t2  <= (q24 > CFG_W'(TILE_MIN)) ? coord_t'(q24) : coord_t'(TILE_MIN);
    for (int i = 0; i < 9; i++) begin
      bar_x2[i] <= coord_t'((PROD_W'(w1) * PROD_W'(i)) >> 3);
    end
  end

  always_ff @(posedge clk) begin
    w3         <= w2;
    h3         <= h2;
    b3         <= b2;
    mw3        <= mw2;
    mh3        <= mh2;
    ox3        <= half_tz(w2 - (t2 <<< 3));
    oy3        <= half_tz(h2 - (t2 <<< 2) - (t2 <<< 1));
    mky3       <= (h2 >>> 1) - (mh2 >>> 1);
    grn_x0_3   <= w2 - b2 - mw2;
    inner_x1_3 <= w2 - b2;
    blu_x0_3   <= (w2 >>> 1) - (mw2 >>> 1);
    blu_y0_3   <= h2 - b2 - mh2;
    inner_y1_3 <= h2 - b2;
    bar_y1_3   <= b2 + bh2;
    red_x1_3   <= b2 + mw2;
    for (int k = 0; k < 9; k++) begin
      kt3[k]    <= t2 * coord_t'(k);
      bar_x3[k] <= bar_x2[k];
    end
  end

  always_ff @(posedge clk) begin
    geom.w        <= w3;
    geom.h        <= h3;
    geom.b        <= b3;
    geom.bar_y1   <= bar_y1_3;
    geom.red_x1   <= red_x1_3;
    geom.mk_y0    <= mky3;
    geom.mk_y1    <= mky3 + mh3;
    geom.grn_x0   <= grn_x0_3;
    geom.inner_x1 <= inner_x1_3;
    geom.blu_x0   <= blu_x0_3;
    geom.blu_x1   <= blu_x0_3 + mw3;
    geom.blu_y0   <= blu_y0_3;
    geom.inner_y1 <= inner_y1_3;
    for (int k = 0; k < 9; k++) begin
      geom.bar_x[k] <= bar_x3[k];
      geom.chk_x[k] <= ox3 + kt3[k];
    end
    for (int k = 0; k < 7; k++) begin
      geom.chk_y[k] <= oy3 + kt3[k];
    end
  end

endmodule

FILE: rtl/tpg_pixel.sv
module tpg_pixel (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        hold,
  input  tpg_pkg::geom_t              geom,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tpg_pkg::COORD_W-1:0] pixel_x,
  input  logic [tpg_pkg::COORD_W-1:0] pixel_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tpg_pkg::COLOR_W-1:0] pixel_color,
  output logic                        inside_res
);
  import tpg_pkg::*;

  localparam logic [COLOR_W-1:0] BG_COLOR     = 24'h27475f;
  localparam logic [COLOR_W-1:0] RED_COLOR    = 24'hff3030;
  localparam logic [COLOR_W-1:0] GRN_COLOR    = 24'h30ff30;
  localparam logic [COLOR_W-1:0] BLU_COLOR    = 24'h3060ff;
  localparam logic [COLOR_W-1:0] CHK_LIGHT    = 24'hd8e8e8;
  localparam logic [COLOR_W-1:0] CHK_DARK     = 24'h304050;
  localparam logic [COLOR_W-1:0] BORDER_COLOR = 24'hf0f0f0;
  localparam logic [COLOR_W-1:0] BAR_COLOR [8] = '{
    24'hffffff, 24'hffff00, 24'h00ffff, 24'h00ff00,
    24'hff00ff, 24'hff0000, 24'h0000ff, 24'h202020
  };

  function automatic logic ge(coord_t a, coord_t c);
    return a >= c;
  endfunction

  function automatic logic lt(coord_t a, coord_t c);
    return a < c;
  endfunction

  function automatic logic in_rect(coord_t px, coord_t py, coord_t x0, coord_t x1,
                                   coord_t y0, coord_t y1);
    return ge(px, x0) && lt(px, x1) && ge(py, y0) && lt(py, y1);
  endfunction

  logic               s1_valid;
  logic [COORD_W-1:0] s1_x, s1_y;
  logic               out_en, s1_take;

  coord_t             px, py;
  logic               in_frame;
  logic               col_odd, row_odd;
  logic [COLOR_W-1:0] color;

  assign out_en   = !out_valid || out_ready;
  assign s1_take  = !s1_valid || out_en;
  assign in_ready = s1_take && !hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid <= in_valid && in_ready;
      end
      if (out_en) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_x <= pixel_x;
      s1_y <= pixel_y;
    end
    if (out_en && s1_valid) begin
      pixel_color <= color;
      inside_res  <= in_frame;
    end
  end

  // Layers are painted in order; a later layer wins.
  always_comb begin
    px       = coord_t'(s1_x);
    py       = coord_t'(s1_y);
    in_frame = lt(px, geom.w) && lt(py, geom.h);
    color    = BG_COLOR;
    for (int i = 0; i < 8; i++) begin
      if (in_rect(px, py, geom.bar_x[i], geom.bar_x[i+1], geom.b, geom.bar_y1)) begin
        color = BAR_COLOR[i];
      end
    end
    if (in_rect(px, py, geom.b, geom.red_x1, geom.mk_y0, geom.mk_y1)) begin
      color = RED_COLOR;
    end
    if (in_rect(px, py, geom.grn_x0, geom.inner_x1, geom.mk_y0, geom.mk_y1)) begin
      color = GRN_COLOR;
    end
    if (in_rect(px, py, geom.blu_x0, geom.blu_x1, geom.blu_y0, geom.inner_y1)) begin
      color = BLU_COLOR;
    end
    // The tile index is the number of tile edges passed, so its parity is
    // the XOR of the edge compares.
    col_odd = 1'b0;
    for (int k = 1; k < 8; k++) begin
      col_odd = col_odd ^ ge(px, geom.chk_x[k]);
    end
    row_odd = 1'b0;
    for (int k = 1; k < 6; k++) begin
      row_odd = row_odd ^ ge(py, geom.chk_y[k]);
    end
    if (in_rect(px, py, geom.chk_x[0], geom.chk_x[8], geom.chk_y[0], geom.chk_y[6])) begin
      color = (col_odd ^ row_odd) ? CHK_LIGHT : CHK_DARK;
    end
    if (lt(px, geom.b) || lt(py, geom.b) ||
        ge(px, geom.inner_x1) || ge(py, geom.inner_y1)) begin
      color = BORDER_COLOR;
    end
    if (!in_frame) begin
      color = '0;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !inside_res |-> pixel_color == '0)
    else $error("pixel outside the frame carries a color");
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_valid |=> out_valid)
    else $error("input stage word not moved into the output register");
`endif

endmodule

FILE: rtl/test_pattern_pixel_generator_core.sv
// An accepted word passes through the input stage and then the output register.
// Throughput: one word per cycle while out_ready is high and the input is not held
// off; the output register and the input stage let a new word in while a finished
// result waits to be taken. Reset loads a 640 by 480 frame. After reset and after
// each register write, the input is held off while the geometry pipeline refills.
module test_pattern_pixel_generator_core #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tpg_pkg::IDX_W-1:0]   cfg_index,
  input  logic [tpg_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tpg_pkg::COORD_W-1:0] pixel_x,
  input  logic [tpg_pkg::COORD_W-1:0] pixel_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tpg_pkg::COLOR_W-1:0] pixel_color,
  output logic                        inside_res
);
  import tpg_pkg::*;

  logic [CFG_W-1:0] frame_width, frame_height;
  logic             busy;
  logic             hold;
  geom_t            geom;

  assign hold = busy || cfg_we;

  tpg_cfg #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .busy         (busy)
  );

  tpg_geom u_geom (
    .clk          (clk),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .geom         (geom)
  );

  tpg_pixel u_pixel (
    .clk         (clk),
    .rst         (rst),
    .hold        (hold),
    .geom        (geom),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_color (pixel_color),
    .inside_res  (inside_res)
  );

endmodule

FILE: sim/test_pattern_pixel_generator_core_tb.sv
module test_pattern_pixel_generator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpg_pkg::*;

  localparam int MAX_DIM = 4096;

  localparam logic [IDX_W-1:0] REG_UNUSED_LO    = 2'd2;
  localparam logic [IDX_W-1:0] REG_UNUSED_HI    = 2'd3;

  localparam logic [COLOR_W-1:0] RGB_BACKGROUND = 24'h27475f;
  localparam logic [COLOR_W-1:0] RGB_RED_MARK   = 24'hff3030;
  localparam logic [COLOR_W-1:0] RGB_GREEN_MARK = 24'h30ff30;
  localparam logic [COLOR_W-1:0] RGB_BLUE_MARK  = 24'h3060ff;
  localparam logic [COLOR_W-1:0] RGB_TILE_ODD   = 24'hd8e8e8;
  localparam logic [COLOR_W-1:0] RGB_TILE_EVEN  = 24'h304050;
  localparam logic [COLOR_W-1:0] RGB_BORDER     = 24'hf0f0f0;
  localparam logic [8*COLOR_W-1:0] RGB_BARS = {
    24'h202020, 24'h0000ff, 24'hff0000, 24'hff00ff,
    24'h00ff00, 24'h00ffff, 24'hffff00, 24'hffffff
  };

  typedef struct {
    int                 px;
    int                 py;
    logic [COLOR_W-1:0] color;
    logic               in_frame;
  } pixel_result_t;

  class pattern_scoreboard;
    int frame_w;
    int frame_h;
    int errors;
    pixel_result_t pending[$];

    function new();
      frame_w = 640;
      frame_h = 480;
      errors = 0;
    endfunction

    function int clamp_dim(int v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_FRAME_WIDTH) frame_w = clamp_dim(int'(data));
      else if (idx == REG_FRAME_HEIGHT) frame_h = clamp_dim(int'(data));
    endfunction

    function bit in_box(int px, int py, int x, int y, int bw, int bh);
      if (bw <= 0 || bh <= 0) return 0;
      return px >= x && px < x + bw && py >= y && py < y + bh;
    endfunction

    function logic [COLOR_W-1:0] expected_rgb(int px, int py);
      int w, h, b, bar_h, mk_w, mk_h, t, ox, oy, left, right;
      logic [COLOR_W-1:0] c;
      w = frame_w;
      h = frame_h;
      b = (w < 64 || h < 64) ? 1 : 4;
      bar_h = (h / 7 > 12) ? h / 7 : 12;
      mk_w = (w / 18 > 4) ? w / 18 : 4;
      mk_h = (h / 5 > 4) ? h / 5 : 4;
      t = ((w < h ? w : h) / 24 > 2) ? (w < h ? w : h) / 24 : 2;
      ox = (w - t * 8) / 2;
      oy = (h - t * 6) / 2;
      c = RGB_BACKGROUND;
      for (int i = 0; i < 8; i++) begin
        left = w * i / 8;
        right = w * (i + 1) / 8;
        if (in_box(px, py, left, b, right - left, bar_h)) c = RGB_BARS[i*COLOR_W +: COLOR_W];
      end
      if (in_box(px, py, b, h / 2 - mk_h / 2, mk_w, mk_h)) c = RGB_RED_MARK;
      if (in_box(px, py, w - b - mk_w, h / 2 - mk_h / 2, mk_w, mk_h)) c = RGB_GREEN_MARK;
      if (in_box(px, py, w / 2 - mk_w / 2, h - b - mk_h, mk_w, mk_h)) c = RGB_BLUE_MARK;
      if (in_box(px, py, ox, oy, t * 8, t * 6)) begin
        c = ((((px - ox) / t) + ((py - oy) / t)) & 1) ? RGB_TILE_ODD : RGB_TILE_EVEN;
      end
      if (px < b || py < b || px >= w - b || py >= h - b) c = RGB_BORDER;
      return c;
    endfunction

    function void note_pixel(int px, int py);
      pixel_result_t r;
      r.px = px;
      r.py = py;
      if (px >= frame_w || py >= frame_h) begin
        r.color = '0;
        r.in_frame = 1'b0;
      end else begin
        r.color = expected_rgb(px, py);
        r.in_frame = 1'b1;
      end
      pending.push_back(r);
    endfunction

    task report_mismatch(string what, int px, int py, int got, int want);
      if (errors < 40) begin
        $display("mismatch in %s at (%0d,%0d): got %h, expected %h", what, px, py, got, want);
      end
      errors++;
    endtask

    task check_pixel(logic [COLOR_W-1:0] color, logic in_frame);
      pixel_result_t r;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", -1, -1, int'(color), 0);
      end else begin
        r = pending.pop_front();
        if (color !== r.color) begin
          report_mismatch("pixel_color", r.px, r.py, int'(color), int'(r.color));
        end
        if (in_frame !== r.in_frame) begin
          report_mismatch("inside_res", r.px, r.py, int'(in_frame), int'(r.in_frame));
        end
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [COORD_W-1:0]   pixel_x = '0;
  logic [COORD_W-1:0]   pixel_y = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COLOR_W-1:0]   pixel_color;
  logic                 inside_res;

  pattern_scoreboard sb = new();
  bit busy_run = 1'b0;
  bit hold_req = 1'b0;

  test_pattern_pixel_generator_core #(
    .MAX_DIMENSION(MAX_DIM)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pixel_color(pixel_color),
    .inside_res(inside_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (busy_run || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly inside the frame, some near its right or bottom edge, the rest anywhere.
  function int rand_coord(int lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return int'($urandom_range(0, lim - 1));
    if (r < 90) begin
      return int'($urandom_range(lim > 4 ? lim - 4 : 0, lim + 3 > 4095 ? 4095 : lim + 3));
    end
    return int'($urandom_range(0, 4095));
  endfunction

  task idle_sender(int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task offer_pixel(int px, int py);
    @(negedge clk);
    in_valid <= 1'b1;
    pixel_x <= px[COORD_W-1:0];
    pixel_y <= py[COORD_W-1:0];
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(px, py);
    idle_sender(pick_gap());
  endtask

  task write_reg(logic [IDX_W-1:0] idx, int data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data[CFG_W-1:0]);
  endtask

  task drain();
    idle_sender(1);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall_left = 300;
        hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_pixel(pixel_color, inside_res);
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 12; ph++) begin
      busy_run = (ph % 3 == 1);
      if (ph > 0) begin
        drain();
        case (ph)
          1: begin
            write_reg(REG_FRAME_WIDTH, 0);
            write_reg(REG_FRAME_HEIGHT, 0);
          end
          2: begin
            write_reg(REG_FRAME_WIDTH, 8191);
            write_reg(REG_FRAME_HEIGHT, 5000);
          end
          3: begin
            write_reg(REG_FRAME_WIDTH, 1);
            write_reg(REG_FRAME_HEIGHT, 4096);
          end
          4: begin
            write_reg(REG_FRAME_WIDTH, 4096);
            write_reg(REG_FRAME_HEIGHT, 1);
          end
          5: begin
            write_reg(REG_FRAME_WIDTH, 63);
            write_reg(REG_FRAME_HEIGHT, 64);
            write_reg(REG_UNUSED_LO, $urandom_range(0, 8191));
          end
          6: begin
            write_reg(REG_FRAME_WIDTH, 64);
            write_reg(REG_FRAME_HEIGHT, 64);
            write_reg(REG_UNUSED_HI, $urandom_range(0, 8191));
          end
          7: begin
            write_reg(REG_FRAME_WIDTH, 4097);
            write_reg(REG_FRAME_HEIGHT, 2);
          end
          11: begin
            write_reg(REG_FRAME_WIDTH, $urandom_range(0, 8191));
            write_reg(REG_FRAME_HEIGHT, $urandom_range(0, 8191));
            write_reg(REG_UNUSED_LO, 0);
          end
          default: begin
            write_reg(REG_FRAME_WIDTH, $urandom_range(1, 400));
            write_reg(REG_FRAME_HEIGHT, $urandom_range(1, 400));
          end
        endcase
      end
      if (ph == 4 || ph == 10) hold_req = 1'b1;

      if (ph == 0) begin
        // Corners, the frame edges and the coordinate extremes of the reset frame.
        offer_pixel(0, 0);
        offer_pixel(639, 479);
        offer_pixel(640, 0);
        offer_pixel(0, 480);
        offer_pixel(4095, 4095);
        offer_pixel(4095, 0);
        offer_pixel(0, 4095);
        offer_pixel(3, 100);
        offer_pixel(4, 100);
        // One pixel in each colour bar, then its last row and the row below.
        for (int i = 0; i < 8; i++) offer_pixel(80 * i + 40, 4);
        offer_pixel(100, 71);
        offer_pixel(100, 72);
        offer_pixel(20, 240);
        offer_pixel(600, 240);
        offer_pixel(320, 400);
        offer_pixel(240, 180);
        offer_pixel(259, 180);
        offer_pixel(260, 180);
        offer_pixel(400, 299);
      end

      repeat (ph == 0 ? 40 : 62) offer_pixel(rand_coord(sb.frame_w), rand_coord(sb.frame_h));
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tpg_pkg.sv
rtl/tpg_cfg.sv
rtl/tpg_geom.sv
rtl/tpg_pixel.sv
rtl/test_pattern_pixel_generator_core.sv
sim/test_pattern_pixel_generator_core_tb.sv
